/* rtl/utf8_strict_stream_decoder_unit_macros.svh */
// Assertion helpers used by the decode module.
`ifndef UTF8_STRICT_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STRICT_STREAM_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies a consequence in the same cycle.
`define U8SD_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Check that a condition implies a consequence in the following cycle.
`define U8SD_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define U8SD_ASSERT_SAME(label, clk, rst, cond, cons)
`define U8SD_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

/* rtl/u8sd_pkg.sv */
package u8sd_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ILLEGAL   = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   // Byte ranges and special lead bytes
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD_MIN     = 8'hC2;
   localparam logic [7:0] LEAD_MAX     = 8'hF4;
   localparam logic [7:0] LEAD_THREE   = 8'hE0;
   localparam logic [7:0] LEAD_FOUR    = 8'hF0;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] CONT_A0      = 8'hA0;
   localparam logic [7:0] CONT_90      = 8'h90;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [20:0] SCALAR_MAX  = 21'h10FFFF;

   // One accepted input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_buffer;
      logic       last_of_buffer;
   } in_item_type;

   // One result item
   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  seq_length;
      status_type  status;
      logic [15:0] char_count;
   } out_item_type;

endpackage

/* rtl/u8sd_req_if.sv */
interface u8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_buffer;
   logic       last_of_buffer;

   modport source (output valid, output data_byte, output first_of_buffer,
                   output last_of_buffer, input ready);
   modport sink (input valid, input data_byte, input first_of_buffer,
                 input last_of_buffer, output ready);
endinterface

/* rtl/u8sd_rsp_if.sv */
interface u8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [2:0]  seq_length;
   logic [1:0]  status;
   logic [15:0] char_count;

   modport source (output valid, output code_point, output seq_length,
                   output status, output char_count, input ready);
   modport sink (input valid, input code_point, input seq_length,
                 input status, input char_count, output ready);
endinterface

/* rtl/u8sd_in_stage.sv */
module u8sd_in_stage import u8sd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   u8sd_req_if.sink     req_chan,
   input  logic         advance,
   output logic         item_valid,
   output in_item_type  item
);

   logic        valid_ff, valid_in;
   in_item_type item_ff, item_in;
   logic        take;

   // Accept a new item when the register is empty or drains this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in = item_ff;
      if (take) begin
         item_in.data_byte = req_chan.data_byte;
         item_in.first_of_buffer = req_chan.first_of_buffer;
         item_in.last_of_buffer = req_chan.last_of_buffer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

/* rtl/u8sd_decode.sv */
module u8sd_decode import u8sd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  in_item_type   item,
   output logic          res_valid,
   output out_item_type  res
);
`include "utf8_strict_stream_decoder_unit_macros.svh"

   logic [1:0]  pending_ff, pending_in;
   logic [7:0]  lead_ff, lead_in;
   logic [20:0] partial_ff, partial_in;
   logic [2:0]  total_ff, total_in;
   logic        second_ff, second_in;
   logic [15:0] count_ff, count_in;

   logic [7:0]  b;
   logic [1:0]  pend_eff;
   logic        second_eff;
   logic [15:0] count_eff;
   logic [15:0] count_inc;
   logic        second_good;
   logic [20:0] shifted;

   assign b = item.data_byte;
   // Buffer start clears the decoder state and the count before this byte
   assign pend_eff = item.first_of_buffer ? 2'd0 : pending_ff;
   assign second_eff = item.first_of_buffer ? 1'b0 : second_ff;
   assign count_eff = item.first_of_buffer ? 16'd0 : count_ff;
   assign count_inc = (count_eff != COUNT_MAX) ? count_eff + 16'd1 : count_eff;
   assign shifted = {partial_ff[14:0], b[5:0]};

   // Range check on the second byte for leads with tighter limits
   always_comb begin
      priority if (lead_ff == LEAD_E0) begin
         second_good = (b >= CONT_A0);
      end else if (lead_ff == LEAD_ED) begin
         second_good = (b < CONT_A0);
      end else if (lead_ff == LEAD_F0) begin
         second_good = (b >= CONT_90);
      end else if (lead_ff == LEAD_F4) begin
         second_good = (b < CONT_90);
      end else begin
         second_good = 1'b1;
      end
   end

   // Decode the byte against the pending state
   always_comb begin
      pending_in = pending_ff;
      lead_in = lead_ff;
      partial_in = partial_ff;
      total_in = total_ff;
      second_in = second_ff;
      count_in = count_ff;
      res_valid = 1'b0;
      res.code_point = 21'd0;
      res.seq_length = 3'd0;
      res.status = STATUS_OK;
      res.char_count = count_eff;
      if (advance) begin
         pending_in = 2'd0;
         second_in = 1'b0;
         count_in = count_eff;
         if (pend_eff == 2'd0) begin
            if (b < ASCII_LIMIT) begin
               res_valid = 1'b1;
               res.code_point = {13'd0, b};
               res.seq_length = 3'd1;
               res.char_count = count_inc;
               count_in = count_inc;
            end else if (b < LEAD_MIN || b > LEAD_MAX) begin
               res_valid = 1'b1;
               res.status = STATUS_ILLEGAL;
            end else begin
               lead_in = b;
               if (b < LEAD_THREE) begin
                  total_in = 3'd2;
                  partial_in = {16'd0, b[4:0]};
               end else if (b < LEAD_FOUR) begin
                  total_in = 3'd3;
                  partial_in = {17'd0, b[3:0]};
               end else begin
                  total_in = 3'd4;
                  partial_in = {18'd0, b[2:0]};
               end
               if (item.last_of_buffer) begin
                  res_valid = 1'b1;
                  res.status = STATUS_TRUNCATED;
               end else begin
                  pending_in = total_in[1:0] - 2'd1;
                  second_in = 1'b1;
               end
            end
         end else if (b[7:6] != 2'b10 || (second_eff && !second_good)) begin
            // Drop the sequence on a bad continuation byte
            res_valid = 1'b1;
            res.status = STATUS_ILLEGAL;
         end else if (pend_eff == 2'd1) begin
            res_valid = 1'b1;
            res.code_point = shifted;
            res.seq_length = total_ff;
            res.char_count = count_inc;
            count_in = count_inc;
         end else if (item.last_of_buffer) begin
            res_valid = 1'b1;
            res.status = STATUS_TRUNCATED;
         end else begin
            pending_in = pend_eff - 2'd1;
            partial_in = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         second_ff <= 1'b0;
         count_ff <= 16'd0;
         lead_ff <= 8'd0;
         partial_ff <= 21'd0;
         total_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
         second_ff <= second_in;
         count_ff <= count_in;
         lead_ff <= lead_in;
         partial_ff <= partial_in;
         total_ff <= total_in;
      end
   end

   `U8SD_ASSERT_SAME(a_ok_scalar, clock, reset, res_valid && res.status == STATUS_OK, res.seq_length != 3'd0 && res.code_point <= SCALAR_MAX && (res.code_point < 21'h00D800 || res.code_point > 21'h00DFFF))
   `U8SD_ASSERT_SAME(a_err_zero, clock, reset, res_valid && res.status != STATUS_OK, res.code_point == 21'd0 && res.seq_length == 3'd0)
   `U8SD_ASSERT_NEXT(a_idle_after_result, clock, reset, res_valid, pending_ff == 2'd0)

endmodule

/* rtl/u8sd_out_stage.sv */
module u8sd_out_stage import u8sd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   u8sd_rsp_if.source    rsp_chan,
   input  logic          load,
   input  out_item_type  res,
   output logic          free
);

   logic         valid_ff, valid_in;
   out_item_type item_ff, item_in;

   // Register can take a result when empty or when the item leaves
   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);
      item_in = load ? res : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.code_point = item_ff.code_point;
   assign rsp_chan.seq_length = item_ff.seq_length;
   assign rsp_chan.status = item_ff.status;
   assign rsp_chan.char_count = item_ff.char_count;

endmodule

/* rtl/utf8_strict_stream_decoder_unit.sv */
// Strict UTF-8 byte stream decoder.
// req_chan carries one byte per item with first_of_buffer and last_of_buffer
// flags; rsp_chan returns decoded characters and error reports, each with
// code_point, seq_length, status (ok, illegal, truncated) and char_count.
// A byte that only continues a sequence gives no result item; a completed
// character, an illegal byte or a sequence cut off by last_of_buffer gives one.
// Path: a byte accepted into the input register is decoded combinationally from
// there, and its result goes into the output register that drives rsp_chan.valid.
// Throughput: one byte per cycle while the output register has room, set by the
// single decode pass between the input register and the output register.
// Stall: while rsp_chan is held off, the output register keeps its item and
// the input register keeps one more byte; req_chan.ready drops only when both
// are full, and a byte that yields no result also waits for that room.
// Reset (synchronous, active high) empties both registers, returns the
// decoder to idle and clears the character count.
module utf8_strict_stream_decoder_unit import u8sd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   u8sd_req_if.sink   req_chan,
   u8sd_rsp_if.source rsp_chan
);

   logic         item_valid;
   in_item_type  item;
   logic         out_free;
   logic         advance;
   logic         res_valid;
   out_item_type res;

   assign advance = item_valid && out_free;

   u8sd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   u8sd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   u8sd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_chan (rsp_chan),
      .load     (res_valid),
      .res      (res),
      .free     (out_free)
   );

endmodule

/* test/utf8_strict_stream_decoder_unit_tb.sv */
module utf8_strict_stream_decoder_unit_tb;
   import u8sd_pkg::*;

   // Track decoder state and the queue of predicted result items
   class decode_scoreboard;
      out_item_type expected_q[$];
      int unsigned  mismatches;
      logic [1:0]   cont_left;
      logic [7:0]   lead;
      logic [20:0]  acc;
      logic [2:0]   seq_len;
      logic [2:0]   seen;
      logic [15:0]  chars;

      function new();
         clear_sequence();
         chars = '0;
         mismatches = 0;
      endfunction

      function void clear_sequence();
         cont_left = '0;
         lead = '0;
         acc = '0;
         seq_len = '0;
         seen = '0;
      endfunction

      // Restrict the second byte after the leads that guard against
      // overlong forms, surrogates and scalars above the top plane
      function bit second_byte_allowed(logic [7:0] b);
         case (lead)
            LEAD_E0: return b >= CONT_A0;
            LEAD_ED: return b < CONT_A0;
            LEAD_F0: return b >= CONT_90;
            LEAD_F4: return b < CONT_90;
            default: return 1'b1;
         endcase
      endfunction

      // Queue one result and return to idle; count good characters
      function void push_result(logic [20:0] cp, logic [2:0] len, status_type st);
         out_item_type r;
         if (st == STATUS_OK && chars != COUNT_MAX) chars++;
         clear_sequence();
         r.code_point = cp;
         r.seq_length = len;
         r.status = st;
         r.char_count = chars;
         expected_q.push_back(r);
      endfunction

      // Advance the predicted decoder by one accepted byte
      function void note_input(logic [7:0] b, logic first, logic last);
         if (first) begin
            clear_sequence();
            chars = '0;
         end
         if (cont_left == 2'd0) begin
            if (b < ASCII_LIMIT) begin
               push_result({13'd0, b}, 3'd1, STATUS_OK);
            end else if (b < LEAD_MIN || b > LEAD_MAX) begin
               push_result('0, '0, STATUS_ILLEGAL);
            end else begin
               lead = b;
               seen = 3'd1;
               if (b < LEAD_THREE) begin
                  seq_len = 3'd2;
                  acc = {16'd0, b[4:0]};
               end else if (b < LEAD_FOUR) begin
                  seq_len = 3'd3;
                  acc = {17'd0, b[3:0]};
               end else begin
                  seq_len = 3'd4;
                  acc = {18'd0, b[2:0]};
               end
               cont_left = 2'(seq_len - 3'd1);
               if (last) push_result('0, '0, STATUS_TRUNCATED);
            end
         end else if (b[7:6] != 2'b10 || (seen == 3'd1 && !second_byte_allowed(b))) begin
            push_result('0, '0, STATUS_ILLEGAL);
         end else begin
            acc = {acc[14:0], b[5:0]};
            seen = seen + 3'd1;
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) push_result(acc, seq_len, STATUS_OK);
            else if (last) push_result('0, '0, STATUS_TRUNCATED);
         end
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= 50) $display("MISMATCH: %s", what);
      endtask

      // Compare one result item with the oldest prediction
      task check_result(input out_item_type got);
         out_item_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result cp=%h len=%0d st=%0d cnt=%0d",
                                      got.code_point, got.seq_length, got.status,
                                      got.char_count));
            return;
         end
         want = expected_q.pop_front();
         if (got.code_point !== want.code_point)
            report_mismatch($sformatf("code_point got %h expected %h",
                                      got.code_point, want.code_point));
         if (got.seq_length !== want.seq_length)
            report_mismatch($sformatf("seq_length got %0d expected %0d",
                                      got.seq_length, want.seq_length));
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      got.status, want.status));
         if (got.char_count !== want.char_count)
            report_mismatch($sformatf("char_count got %0d expected %0d",
                                      got.char_count, want.char_count));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   no_idle;

   logic [7:0] byte_q[$];
   decode_scoreboard sb = new();

   u8sd_req_if req_if();
   u8sd_rsp_if rsp_if();

   utf8_strict_stream_decoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result side now and then
   always @(posedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(99) >= 8);
   end

   // Note accepted bytes and check returned items
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_input(req_if.data_byte, req_if.first_of_buffer, req_if.last_of_buffer);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.code_point, rsp_if.seq_length, rsp_if.status,
                             rsp_if.char_count});
      end
   end

   // Offer one byte, with random gaps, and hold it until accepted
   task automatic send_item(input logic [7:0] b, input bit first, input bit last);
      if (!no_idle) begin
         while ($urandom_range(99) < 8) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.first_of_buffer <= first;
      req_if.last_of_buffer <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Hold off the sender until every predicted item has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Pick a scalar that encodes to the given length, edges now and then
   function automatic logic [20:0] pick_scalar(int unsigned len);
      logic [20:0] lo, hi, cp;
      case (len)
         1: begin lo = 21'h0; hi = 21'h7F; end
         2: begin lo = 21'h80; hi = 21'h7FF; end
         3: begin lo = 21'h800; hi = 21'hFFFF; end
         default: begin lo = 21'h10000; hi = SCALAR_MAX; end
      endcase
      if ($urandom_range(7) == 0) return $urandom_range(1) ? lo : hi;
      cp = 21'($urandom_range(hi, lo));
      // move surrogates down into the ordinary three-byte range
      if (len == 3 && cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h4000;
      return cp;
   endfunction

   function automatic void append_char(logic [20:0] cp, int unsigned len);
      case (len)
         1: byte_q.push_back({1'b0, cp[6:0]});
         2: begin
            byte_q.push_back({3'b110, cp[10:6]});
            byte_q.push_back({2'b10, cp[5:0]});
         end
         3: begin
            byte_q.push_back({4'b1110, cp[15:12]});
            byte_q.push_back({2'b10, cp[11:6]});
            byte_q.push_back({2'b10, cp[5:0]});
         end
         default: begin
            byte_q.push_back({5'b11110, cp[20:18]});
            byte_q.push_back({2'b10, cp[17:12]});
            byte_q.push_back({2'b10, cp[11:6]});
            byte_q.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // End the run if the block hangs
   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int unsigned sent, len, pick, n_chars;
      bit          end_flag;
      logic [7:0]  lead_b;

      reset = 1'b1;
      no_idle = 1'b0;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.first_of_buffer = 1'b0;
      req_if.last_of_buffer = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: ASCII bounds, bad leads, range guards, bad continuation
      byte_q = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hC2, 8'h80, 8'hE0, 8'h9F,
                 8'hED, 8'hA0, 8'hE0, 8'hA0, 8'h80, 8'hF0, 8'h8F, 8'hF4,
                 8'h90, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF5, 8'hFF, 8'hE1, 8'h41};
      foreach (byte_q[i]) send_item(byte_q[i], i == 0, 1'b0);
      // truncated at a lead, truncated mid-sequence, error on the last byte
      send_item(8'hC3, 1'b0, 1'b1);
      send_item(8'hF0, 1'b0, 1'b0);
      send_item(8'hA0, 1'b0, 1'b1);
      send_item(8'hE2, 1'b0, 1'b0);
      send_item(8'hC0, 1'b0, 1'b1);
      drain_results();

      // Unbroken ASCII stream with no idling on either side, then a two-byte character and an illegal last byte
      no_idle <= 1'b1;
      for (int i = 0; i < 200; i++)
         send_item(8'($urandom_range(127)), i == 0, 1'b0);
      send_item(8'hC2, 1'b0, 1'b0);
      send_item(8'hA9, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      drain_results();
      no_idle <= 1'b0;

      // Random buffers: mostly well-formed characters, some broken
      sent = 0;
      while (sent < 850) begin
         byte_q.delete();
         n_chars = $urandom_range(12, 1);
         repeat (n_chars) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               len = $urandom_range(4, 1);
               append_char(pick_scalar(len), len);
            end else if (pick < 80) begin
               // cut a multibyte character short
               len = $urandom_range(4, 2);
               append_char(pick_scalar(len), len);
               repeat ($urandom_range(len - 1, 1)) void'(byte_q.pop_back());
            end else if (pick < 88) begin
               // overwrite one continuation byte
               len = $urandom_range(4, 2);
               append_char(pick_scalar(len), len);
               byte_q[byte_q.size() - 1 - $urandom_range(len - 2)] = 8'($urandom_range(255));
            end else if (pick < 94) begin
               // guarded lead with any continuation bytes
               case ($urandom_range(3))
                  0: lead_b = LEAD_E0;
                  1: lead_b = LEAD_ED;
                  2: lead_b = LEAD_F0;
                  default: lead_b = LEAD_F4;
               endcase
               byte_q.push_back(lead_b);
               repeat (lead_b >= LEAD_FOUR ? 3 : 2)
                  byte_q.push_back(8'h80 | 8'($urandom_range(63)));
            end else begin
               byte_q.push_back(8'($urandom_range(255)));
            end
         end
         end_flag = ($urandom_range(4) != 0);
         foreach (byte_q[i])
            send_item(byte_q[i], i == 0, end_flag && i == byte_q.size() - 1);
         sent += byte_q.size();
         if ($urandom_range(14) == 0) drain_results();
      end

      // Wait out the last results, then give the verdict
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
